### design/reduced_round_aes_cipher_core_defines.svh
// -----------------------------------------------------------------------------
// Reduced-round AES cipher core: assertion macros
// Shared assertion forms, clocked on clk and masked while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef REDUCED_ROUND_AES_CIPHER_CORE_DEFINES_SVH
`define REDUCED_ROUND_AES_CIPHER_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define RRAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define RRAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rrac_pkg.sv
// -----------------------------------------------------------------------------
// Reduced-round AES cipher package
// Types, constants, S-box tables and the byte-level round functions.
// -----------------------------------------------------------------------------
package rrac_pkg;

    localparam int MAX_ROUNDS = 10;
    localparam int KEY_DEPTH  = MAX_ROUNDS + 1;
    localparam int KIDX_W     = $clog2(KEY_DEPTH);
    localparam int RC_W       = 4;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    localparam logic [63:0]     PERM_RESET   = 64'hFEDCBA9876543210;
    localparam logic [RC_W-1:0] ROUNDS_RESET = RC_W'(MAX_ROUNDS);
    localparam logic [7:0]      RCON_FIRST   = 8'h01;

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        REG_SBOX_SELECT = 3'd0,
        REG_NIBBLE_PERM = 3'd1,
        REG_KEY_HIGH    = 3'd2,
        REG_KEY_LOW     = 3'd3,
        REG_ROUND_COUNT = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic dec;
        logic sub_en;
        logic mix_en;
    } round_ctl_t;

    // Entry x sits at bits 2047-8x down.
    localparam logic [2047:0] AES_SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] AES_SBOX_INV = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sub_fwd(input logic [7:0] x, input logic sel,
                                           input logic [63:0] perm);
        if (sel)
            return {perm[{x[7:4], 2'b00} +: 4], perm[{x[3:0], 2'b00} +: 4]};
        return AES_SBOX[{~x, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] sub_inv(input logic [7:0] x, input logic sel,
                                           input logic [63:0] inv_perm);
        if (sel)
            return {inv_perm[{x[7:4], 2'b00} +: 4], inv_perm[{x[3:0], 2'b00} +: 4]};
        return AES_SBOX_INV[{~x, 3'b111} -: 8];
    endfunction

    // Column bytes a0..a3 from the high end.
    function automatic logic [31:0] mix_column(input logic [31:0] col, input logic inv);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int k = 0; k < 4; k++) begin
            a[k]  = col[31-8*k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ a[k];
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        if (inv)
            return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                    m9[0] ^ me[1] ^ mb[2] ^ md[3],
                    md[0] ^ m9[1] ^ me[2] ^ mb[3],
                    mb[0] ^ md[1] ^ m9[2] ^ me[3]};
        return {m2[0] ^ m3[1] ^ a[2] ^ a[3],
                a[0] ^ m2[1] ^ m3[2] ^ a[3],
                a[0] ^ a[1] ^ m2[2] ^ m3[3],
                m3[0] ^ a[1] ^ a[2] ^ m2[3]};
    endfunction

    function automatic logic perm_valid(input logic [63:0] perm);
        logic [15:0] seen;
        seen = '0;
        for (int i = 0; i < 16; i++)
            seen[perm[4*i +: 4]] = 1'b1;
        return &seen;
    endfunction

    // Last writer wins; values that no entry reaches map to zero.
    function automatic logic [63:0] perm_inverse(input logic [63:0] perm);
        logic [63:0] inv;
        inv = '0;
        for (int p = 0; p < 16; p++)
            for (int i = 0; i < 16; i++)
                if (perm[4*i +: 4] == 4'(p))
                    inv[4*p +: 4] = 4'(i);
        return inv;
    endfunction

    function automatic logic [127:0] key_next(input logic [127:0] prev,
                                              input logic [7:0] rcon, input logic sel,
                                              input logic [63:0] perm);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {sub_fwd(prev[23:16], sel, perm) ^ rcon, sub_fwd(prev[15:8], sel, perm),
              sub_fwd(prev[7:0], sel, perm), sub_fwd(prev[31:24], sel, perm)};
        w0 = prev[127:96] ^ t;
        w1 = prev[95:64] ^ w0;
        w2 = prev[63:32] ^ w1;
        w3 = prev[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### design/rrac_ram.sv
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
module rrac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 11,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/rrac_round.sv
// -----------------------------------------------------------------------------
// Round unit
// One cipher round, forward or inverse; SubBytes with ShiftRows and MixColumns
// are each switched in by the control word, and the round key is always added.
// -----------------------------------------------------------------------------
module rrac_round (
    input  logic                 [127:0] state_in,
    input  logic                 [127:0] round_key,
    input  rrac_pkg::round_ctl_t         ctl,
    input  logic                         sbox_sel,
    input  logic                 [63:0]  perm,
    input  logic                 [63:0]  inv_perm,
    output logic                 [127:0] state_out
);

    import rrac_pkg::*;

    logic [127:0] enc_sub;
    logic [127:0] enc_mix;
    logic [127:0] enc_out;
    logic [127:0] dec_add;
    logic [127:0] dec_mix;
    logic [127:0] dec_pre;
    logic [127:0] dec_sub;
    logic [127:0] dec_out;

    // Forward path: byte 4c+r takes row r from column c+r.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                enc_sub[127-8*(4*c+r) -: 8] =
                    sub_fwd(state_in[127-8*(4*((c+r)&3)+r) -: 8], sbox_sel, perm);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            enc_mix[127-32*c -: 32] = mix_column(enc_sub[127-32*c -: 32], 1'b0);
        end
        enc_out = (ctl.mix_en ? enc_mix : (ctl.sub_en ? enc_sub : state_in)) ^ round_key;
    end

    // Inverse path: add key first, then undo MixColumns, then rows and bytes.
    always_comb
    begin
        dec_add = state_in ^ round_key;
        for (int c = 0; c < 4; c++)
        begin
            dec_mix[127-32*c -: 32] = mix_column(dec_add[127-32*c -: 32], 1'b1);
        end
        dec_pre = ctl.mix_en ? dec_mix : dec_add;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                dec_sub[127-8*(4*c+r) -: 8] =
                    sub_inv(dec_pre[127-8*(4*((c-r+4)&3)+r) -: 8], sbox_sel, inv_perm);
            end
        end
        dec_out = ctl.sub_en ? dec_sub : dec_pre;
    end

    assign state_out = ctl.dec ? dec_out : enc_out;

endmodule

### design/reduced_round_aes_cipher_core.sv
// -----------------------------------------------------------------------------
// Reduced-round AES-128 cipher core
// Iterated AES-128 with 1 to 10 rounds, standard or nibble-permutation S-box,
// round keys held in two key memories (high and low halves).
//
//   channel  dir  handshake         payload
//   s_axis   in   tvalid / tready   tdata = block_high, block_low; tuser = op
//   m_axis   out  tvalid / tready   tdata = result_high, result_low; tuser = status
//   apb      in   psel/penable      registers at 8*i, write on access with pready
//
// An item is accepted, then passes through the single round unit once for the
// initial key add and once per configured round, each pass fed by one round key
// read from the key memories the cycle before.
// Reset and every register write rebuild the key schedule, one round key per
// cycle; no item is accepted meanwhile.
// A finished item waits in the output register; the next item is accepted
// and holds in its last round until that register is free.
// -----------------------------------------------------------------------------
`include "reduced_round_aes_cipher_core_defines.svh"

module reduced_round_aes_cipher_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [127:0]                  s_axis_tdata,  // block_high, block_low
    input  logic                          s_axis_tuser,  // op
    // master side
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [127:0]                  m_axis_tdata,  // result_high, result_low
    output logic                          m_axis_tuser,  // status
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrac_pkg::ADDR_W-1:0]   paddr,
    input  logic [rrac_pkg::DATA_W-1:0]   pwdata,
    output logic [rrac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import rrac_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic                sbox_sel_reg;
    logic                sbox_sel_next;
    logic [63:0]         nibble_perm_reg;
    logic [63:0]         nibble_perm_next;
    logic [63:0]         inv_perm_reg;
    logic [63:0]         inv_perm_next;
    logic [63:0]         key_high_reg;
    logic [63:0]         key_high_next;
    logic [63:0]         key_low_reg;
    logic [63:0]         key_low_next;
    logic [RC_W-1:0]     round_count_reg;
    logic [RC_W-1:0]     round_count_next;

    logic [KIDX_W-1:0]   ecnt_reg;
    logic [KIDX_W-1:0]   ecnt_next;
    logic [127:0]        kexp_reg;
    logic [127:0]        kexp_next;
    logic [7:0]          rcon_reg;
    logic [7:0]          rcon_next;

    logic [KIDX_W-1:0]   cnt_reg;
    logic [KIDX_W-1:0]   cnt_next;
    logic [KIDX_W-1:0]   rounds_reg;
    logic [KIDX_W-1:0]   rounds_next;
    logic                dec_reg;
    logic                dec_next;
    logic                bad_reg;
    logic                bad_next;
    logic [127:0]        data_reg;
    logic [127:0]        data_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [127:0]        out_data_reg;
    logic [127:0]        out_data_next;
    logic                out_status_reg;
    logic                out_status_next;

    logic                cfg_wr;
    logic [2:0]          reg_idx;
    logic [KIDX_W-1:0]   rounds_cfg;
    logic                accept;
    logic                out_free;
    logic                last;
    logic [KIDX_W-1:0]   cnt_after;
    logic [KIDX_W-1:0]   key_raddr;
    logic                key_we;
    logic [127:0]        key_wdata;
    logic [127:0]        round_key;
    logic [127:0]        round_out;
    round_ctl_t          ctl;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_comb
    begin
        sbox_sel_next    = sbox_sel_reg;
        nibble_perm_next = nibble_perm_reg;
        inv_perm_next    = inv_perm_reg;
        key_high_next    = key_high_reg;
        key_low_next     = key_low_reg;
        round_count_next = round_count_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_SBOX_SELECT: sbox_sel_next = pwdata[0];
                REG_NIBBLE_PERM:
                begin
                    nibble_perm_next = pwdata;
                    inv_perm_next    = perm_inverse(pwdata);
                end
                REG_KEY_HIGH:    key_high_next    = pwdata;
                REG_KEY_LOW:     key_low_next     = pwdata;
                REG_ROUND_COUNT: round_count_next = pwdata[RC_W-1:0];
                default:         sbox_sel_next    = sbox_sel_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SBOX_SELECT: prdata = {{(DATA_W-1){1'b0}}, sbox_sel_reg};
            REG_NIBBLE_PERM: prdata = nibble_perm_reg;
            REG_KEY_HIGH:    prdata = key_high_reg;
            REG_KEY_LOW:     prdata = key_low_reg;
            REG_ROUND_COUNT: prdata = {{(DATA_W-RC_W){1'b0}}, round_count_reg};
            default:         prdata = '0;
        endcase
    end

    // Clamp zero to one round and saturate at the maximum.
    always_comb
    begin
        if (round_count_reg == '0)
            rounds_cfg = KIDX_W'(1);
        else if (round_count_reg > RC_W'(MAX_ROUNDS))
            rounds_cfg = KIDX_W'(MAX_ROUNDS);
        else
            rounds_cfg = KIDX_W'(round_count_reg);
    end

    // ---------------- key memories ----------------
    rrac_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_key_hi (
        .clk   (clk),
        .we    (key_we),
        .waddr (ecnt_reg),
        .wdata (key_wdata[127:64]),
        .raddr (key_raddr),
        .rdata (round_key[127:64])
    );

    rrac_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH)) u_key_lo (
        .clk   (clk),
        .we    (key_we),
        .waddr (ecnt_reg),
        .wdata (key_wdata[63:0]),
        .raddr (key_raddr),
        .rdata (round_key[63:0])
    );

    // ---------------- round unit ----------------
    rrac_round u_round (
        .state_in  (data_reg),
        .round_key (round_key),
        .ctl       (ctl),
        .sbox_sel  (sbox_sel_reg),
        .perm      (nibble_perm_reg),
        .inv_perm  (inv_perm_reg),
        .state_out (round_out)
    );

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr)
        begin
            state_next = ST_EXPAND;
        end
        else
        begin
            case (state_reg)
                ST_EXPAND: if (ecnt_reg == KIDX_W'(MAX_ROUNDS)) state_next = ST_IDLE;
                ST_IDLE:   if (accept) state_next = ST_RUN;
                ST_RUN:    if (last && out_free) state_next = ST_IDLE;
                default:   state_next = ST_EXPAND;
            endcase
        end
    end

    // ---------------- sequencer: outputs ----------------
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last      = (cnt_reg == rounds_reg);
    assign accept    = s_axis_tvalid && s_axis_tready;
    // Hold the key address while the last pass waits for the output register.
    assign cnt_after = last ? cnt_reg : cnt_reg + KIDX_W'(1);

    always_comb
    begin
        s_axis_tready = 1'b0;
        key_we        = 1'b0;
        key_raddr     = dec_reg ? rounds_reg - cnt_after : cnt_after;
        ctl.dec       = dec_reg;
        ctl.sub_en    = dec_reg ? !last : (cnt_reg != '0);
        ctl.mix_en    = (cnt_reg != '0) && !last;
        case (state_reg)
            ST_EXPAND: key_we = 1'b1;
            ST_IDLE:
            begin
                s_axis_tready = !cfg_wr;
                key_raddr     = s_axis_tuser ? rounds_cfg : '0;
            end
            ST_RUN:    key_we = 1'b0;
            default:   key_we = 1'b0;
        endcase
    end

    // ---------------- key schedule ----------------
    assign key_wdata = (ecnt_reg == '0) ? {key_high_reg, key_low_reg}
                                        : key_next(kexp_reg, rcon_reg, sbox_sel_reg,
                                                   nibble_perm_reg);

    always_comb
    begin
        ecnt_next = ecnt_reg;
        kexp_next = kexp_reg;
        rcon_next = rcon_reg;
        if (cfg_wr)
        begin
            ecnt_next = '0;
            rcon_next = RCON_FIRST;
        end
        else if (state_reg == ST_EXPAND)
        begin
            ecnt_next = ecnt_reg + KIDX_W'(1);
            kexp_next = key_wdata;
            if (ecnt_reg != '0)
                rcon_next = xtime(rcon_reg);
        end
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        data_next       = data_reg;
        cnt_next        = cnt_reg;
        rounds_next     = rounds_reg;
        dec_next        = dec_reg;
        bad_next        = bad_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (accept)
        begin
            data_next   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            cnt_next    = '0;
            rounds_next = rounds_cfg;
            dec_next    = s_axis_tuser;
            bad_next    = sbox_sel_reg && !perm_valid(nibble_perm_reg);
        end
        else if (state_reg == ST_RUN)
        begin
            if (!last)
            begin
                data_next = round_out;
                cnt_next  = cnt_reg + KIDX_W'(1);
            end
            else if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = bad_reg ? '0 : {round_out[63:0], round_out[127:64]};
                out_status_next = bad_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_EXPAND;
            sbox_sel_reg    <= 1'b0;
            nibble_perm_reg <= PERM_RESET;
            inv_perm_reg    <= PERM_RESET;
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            round_count_reg <= ROUNDS_RESET;
            ecnt_reg        <= '0;
            rcon_reg        <= RCON_FIRST;
            cnt_reg         <= '0;
            rounds_reg      <= KIDX_W'(1);
            dec_reg         <= 1'b0;
            bad_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sbox_sel_reg    <= sbox_sel_next;
            nibble_perm_reg <= nibble_perm_next;
            inv_perm_reg    <= inv_perm_next;
            key_high_reg    <= key_high_next;
            key_low_reg     <= key_low_next;
            round_count_reg <= round_count_next;
            ecnt_reg        <= ecnt_next;
            rcon_reg        <= rcon_next;
            cnt_reg         <= cnt_next;
            rounds_reg      <= rounds_next;
            dec_reg         <= dec_next;
            bad_reg         <= bad_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kexp_reg       <= kexp_next;
        data_reg       <= data_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    // ---------------- assertions ----------------
    `RRAC_ASSERT_NEXT(a_accept_starts_run, accept, state_reg == ST_RUN && cnt_reg == '0, "accepted item did not start at pass zero")
    `RRAC_ASSERT_NEXT(a_cfg_restarts_expand, cfg_wr, state_reg == ST_EXPAND && ecnt_reg == '0, "register write did not restart the key schedule")
    `RRAC_ASSERT_NOW(a_no_key_write_in_run, state_reg == ST_RUN, !key_we, "key memory written while an item is in flight")
    `RRAC_ASSERT_NOW(a_pass_in_range, state_reg == ST_RUN, cnt_reg <= rounds_reg && rounds_reg != '0, "round pass counter out of range")

endmodule
